// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the NMS core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, off while reset is asserted.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be true.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    `ASSERT_PROP(label, clk, rst_n, !(expr), msg)

`endif

// File: hdl/gnms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnms_pkg
// Shared widths, codes, direction binning and the pipeline item type.
// ----------------------------------------------------------------------------
package gnms_pkg;

    localparam int MAX_WIDTH_DEF = 4096;
    localparam int MAX_HEIGHT    = 4096;
    localparam int DIM_RESET     = 4096;
    localparam int DIM_W         = 13;
    localparam int ROW_W         = 12;
    localparam int MAG_W         = 16;
    localparam int ANGLE_W       = 13;
    localparam int BIN_W         = 2;
    localparam int WORD_W        = MAG_W + BIN_W;
    localparam int FIFO_DEPTH    = 4;

    // register indexes (paddr[2])
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // input kind on tuser
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    // direction bins
    localparam logic [BIN_W-1:0] DIR_VERT      = 2'd0;
    localparam logic [BIN_W-1:0] DIR_DIAG_MAIN = 2'd1;
    localparam logic [BIN_W-1:0] DIR_HORZ      = 2'd2;
    localparam logic [BIN_W-1:0] DIR_DIAG_ANTI = 2'd3;

    // angles in 1/16 degree
    localparam logic [ANGLE_W-1:0] ANG_180   = 13'd2880;
    localparam logic [ANGLE_W-1:0] ANG_360   = 13'd5760;
    localparam logic [ANGLE_W-1:0] ANG_22_5  = 13'd360;
    localparam logic [ANGLE_W-1:0] ANG_67_5  = 13'd1080;
    localparam logic [ANGLE_W-1:0] ANG_112_5 = 13'd1800;
    localparam logic [ANGLE_W-1:0] ANG_157_5 = 13'd2520;

    typedef struct packed {
        logic              valid;
        logic              emit;
        logic              last;
        logic              up;
        logic              down;
        logic              left;
        logic              right;
        logic [WORD_W-1:0] word;
    } item_t;

    function automatic logic [BIN_W-1:0] angle_bin(input logic [ANGLE_W-1:0] a);
        logic [ANGLE_W-1:0] f;
        logic [BIN_W-1:0]   b;
        if (a >= ANG_360)
        begin
            f = a - ANG_360;
        end
        else if (a >= ANG_180)
        begin
            f = a - ANG_180;
        end
        else
        begin
            f = a;
        end
        if (f <= ANG_22_5 || f > ANG_157_5)
        begin
            b = DIR_VERT;
        end
        else if (f <= ANG_67_5)
        begin
            b = DIR_DIAG_MAIN;
        end
        else if (f <= ANG_112_5)
        begin
            b = DIR_HORZ;
        end
        else
        begin
            b = DIR_DIAG_ANTI;
        end
        return b;
    endfunction

endpackage

// File: hdl/gnms_ring_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnms_ring_mem
// Window ring memory: one write port, two registered read ports.
// Port a returns the word being written when it reads the same entry.
// ----------------------------------------------------------------------------
module gnms_ring_mem #(
    parameter int DEPTH = 2 * gnms_pkg::MAX_WIDTH_DEF + 2,
    parameter int AW    = $clog2(2 * gnms_pkg::MAX_WIDTH_DEF + 2)
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [gnms_pkg::WORD_W-1:0] wr_data,
    input  logic [AW-1:0]               rd_addr_a,
    input  logic [AW-1:0]               rd_addr_b,
    output logic [gnms_pkg::WORD_W-1:0] rd_data_a,
    output logic [gnms_pkg::WORD_W-1:0] rd_data_b
);

    logic [gnms_pkg::WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= (wr_en && (wr_addr == rd_addr_a)) ? wr_data : mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// File: hdl/gnms_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnms_seq
// Frame sequencer: pixel/result counters, ring pointers, item tagging.
// ----------------------------------------------------------------------------
module gnms_seq #(
    parameter int MAX_WIDTH = gnms_pkg::MAX_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   restart,
    input  logic                                   accept,
    input  logic                                   is_flush,
    input  logic [gnms_pkg::MAG_W-1:0]             mag,
    input  logic [gnms_pkg::ANGLE_W-1:0]           angle,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]         width,
    input  logic [gnms_pkg::DIM_W-1:0]             height,
    input  logic [$clog2(MAX_WIDTH*gnms_pkg::MAX_HEIGHT+1)-1:0] total,
    output logic                                   emit_now,
    output logic                                   wr_en,
    output logic [$clog2(2*MAX_WIDTH+2)-1:0]       wr_addr,
    output logic [gnms_pkg::WORD_W-1:0]            wr_data,
    output logic [$clog2(2*MAX_WIDTH+2)-1:0]       rd_addr_mid,
    output logic [$clog2(2*MAX_WIDTH+2)-1:0]       rd_addr_top,
    output gnms_pkg::item_t                        item
);

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int CW    = $clog2(MAX_WIDTH * gnms_pkg::MAX_HEIGHT + 1);
    localparam int CLW   = $clog2(MAX_WIDTH);
    localparam int DEPTH = 2 * MAX_WIDTH + 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int ROW_W = gnms_pkg::ROW_W;

    logic [CW-1:0]    taken_reg;
    logic [CLW-1:0]   col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [AW-1:0]    vp_reg;
    logic [AW-1:0]    rp_mid_reg;
    logic [AW-1:0]    rp_top_reg;
    gnms_pkg::item_t  item_reg;
    gnms_pkg::item_t  item_next;

    logic             full;
    logic             pix_ok;
    logic             fl_ok;
    logic             step;
    logic             primed;
    logic             first;
    logic             col_last;
    logic             row_last;
    logic             frame_done;
    logic [WW-1:0]    off_mid;
    logic [AW-1:0]    off_top;
    logic [AW-1:0]    init_mid;
    logic [AW-1:0]    init_top;
    logic [AW-1:0]    base_wr;
    logic [AW-1:0]    base_mid;
    logic [AW-1:0]    base_top;

    function automatic logic [AW-1:0] inc_ptr(input logic [AW-1:0] a);
        logic [AW-1:0] r;
        if (a == AW'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = a + AW'(1);
        end
        return r;
    endfunction

    always_comb
    begin
        full       = (taken_reg == total);
        pix_ok     = accept && (is_flush == gnms_pkg::ACT_PIXEL) && !full;
        fl_ok      = accept && (is_flush == gnms_pkg::ACT_FLUSH) && full;
        step       = pix_ok || fl_ok;
        primed     = (taken_reg >= (CW'(width) + CW'(1)));
        emit_now   = fl_ok || (pix_ok && primed);
        first      = (taken_reg == '0);
        col_last   = (col_reg == CLW'(width - WW'(1)));
        row_last   = (row_reg == ROW_W'(height - gnms_pkg::DIM_W'(1)));
        frame_done = col_last && row_last;

        // single-row frames: middle tap one column closer, upper row unused
        off_mid  = (height == gnms_pkg::DIM_W'(1)) ? (width - WW'(1)) : width;
        off_top  = AW'({width, 1'b0});
        init_mid = (off_mid == '0) ? '0 : (AW'(DEPTH) - AW'(off_mid));
        init_top = AW'(DEPTH) - off_top;

        base_wr  = first ? '0 : vp_reg;
        base_mid = first ? init_mid : rp_mid_reg;
        base_top = first ? init_top : rp_top_reg;

        wr_en       = pix_ok;
        wr_addr     = base_wr;
        rd_addr_mid = base_mid;
        rd_addr_top = base_top;
        wr_data     = {gnms_pkg::angle_bin(angle), mag};

        item_next.valid = step;
        item_next.emit  = emit_now;
        item_next.last  = fl_ok && frame_done;
        item_next.up    = (row_reg != '0);
        item_next.down  = !row_last;
        item_next.left  = (col_reg != '0);
        item_next.right = !col_last;
        item_next.word  = wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_reg  <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            vp_reg     <= '0;
            rp_mid_reg <= '0;
            rp_top_reg <= '0;
            item_reg   <= '0;
        end
        else
        begin
            item_reg <= item_next;
            if (restart)
            begin
                taken_reg <= '0;
                col_reg   <= '0;
                row_reg   <= '0;
            end
            else
            begin
                if (step)
                begin
                    vp_reg     <= inc_ptr(base_wr);
                    rp_mid_reg <= inc_ptr(base_mid);
                    rp_top_reg <= inc_ptr(base_top);
                end
                if (pix_ok)
                begin
                    taken_reg <= taken_reg + CW'(1);
                end
                if (emit_now)
                begin
                    if (fl_ok && frame_done)
                    begin
                        taken_reg <= '0;
                        col_reg   <= '0;
                        row_reg   <= '0;
                    end
                    else if (col_last)
                    begin
                        col_reg <= '0;
                        row_reg <= row_reg + ROW_W'(1);
                    end
                    else
                    begin
                        col_reg <= col_reg + CLW'(1);
                    end
                end
            end
        end
    end

    assign item = item_reg;

endmodule

// File: hdl/gnms_judge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnms_judge
// 3x3 window registers and the suppression compare.
// ----------------------------------------------------------------------------
module gnms_judge (
    input  logic                        clk,
    input  logic                        rst_n,
    input  gnms_pkg::item_t             item,
    input  logic [gnms_pkg::WORD_W-1:0] mid_word,
    input  logic [gnms_pkg::WORD_W-1:0] top_word,
    output logic                        push,
    output logic [gnms_pkg::MAG_W-1:0]  push_mag,
    output logic                        push_last
);

    localparam int MAG_W = gnms_pkg::MAG_W;

    // column 0 = c-1, 1 = c, 2 = c+1
    logic [MAG_W-1:0]            top_reg [3];
    logic [gnms_pkg::WORD_W-1:0] mid_reg [3];
    logic [MAG_W-1:0]            bot_reg [3];

    logic s2_valid_reg;
    logic s2_last_reg;
    logic s2_up_reg;
    logic s2_down_reg;
    logic s2_left_reg;
    logic s2_right_reg;

    logic [MAG_W-1:0]          mag;
    logic [gnms_pkg::BIN_W-1:0] bin;
    logic [MAG_W-1:0]          nb_a;
    logic [MAG_W-1:0]          nb_b;
    logic                      ok_a;
    logic                      ok_b;
    logic                      suppress;

    always_ff @(posedge clk)
    begin
        if (item.valid)
        begin
            top_reg[0] <= top_reg[1];
            top_reg[1] <= top_reg[2];
            top_reg[2] <= top_word[MAG_W-1:0];
            mid_reg[0] <= mid_reg[1];
            mid_reg[1] <= mid_reg[2];
            mid_reg[2] <= mid_word;
            bot_reg[0] <= bot_reg[1];
            bot_reg[1] <= bot_reg[2];
            bot_reg[2] <= item.word[MAG_W-1:0];
            s2_last_reg  <= item.last;
            s2_up_reg    <= item.up;
            s2_down_reg  <= item.down;
            s2_left_reg  <= item.left;
            s2_right_reg <= item.right;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= item.valid && item.emit;
        end
    end

    always_comb
    begin
        mag  = mid_reg[1][MAG_W-1:0];
        bin  = mid_reg[1][gnms_pkg::WORD_W-1:MAG_W];
        nb_a = '0;
        nb_b = '0;
        ok_a = 1'b0;
        ok_b = 1'b0;
        case (bin)
            gnms_pkg::DIR_VERT:
            begin
                nb_a = top_reg[1];
                ok_a = s2_up_reg;
                nb_b = bot_reg[1];
                ok_b = s2_down_reg;
            end
            gnms_pkg::DIR_DIAG_MAIN:
            begin
                nb_a = top_reg[0];
                ok_a = s2_up_reg && s2_left_reg;
                nb_b = bot_reg[2];
                ok_b = s2_down_reg && s2_right_reg;
            end
            gnms_pkg::DIR_HORZ:
            begin
                nb_a = mid_reg[0][MAG_W-1:0];
                ok_a = s2_left_reg;
                nb_b = mid_reg[2][MAG_W-1:0];
                ok_b = s2_right_reg;
            end
            gnms_pkg::DIR_DIAG_ANTI:
            begin
                nb_a = top_reg[2];
                ok_a = s2_up_reg && s2_right_reg;
                nb_b = bot_reg[0];
                ok_b = s2_down_reg && s2_left_reg;
            end
            default:
            begin
                ok_a = 1'b0;
                ok_b = 1'b0;
            end
        endcase
        suppress  = (ok_a && (mag < nb_a)) || (ok_b && (mag < nb_b));
        push      = s2_valid_reg;
        push_mag  = suppress ? '0 : mag;
        push_last = s2_last_reg;
    end

endmodule

// File: hdl/gnms_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnms_out_fifo
// Result queue with credit count covering results still in the pipeline.
// ----------------------------------------------------------------------------
module gnms_out_fifo (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       reserve,
    input  logic                       push,
    input  logic [gnms_pkg::MAG_W-1:0] push_mag,
    input  logic                       push_last,
    output logic                       in_ready,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [gnms_pkg::MAG_W-1:0] out_mag,
    output logic                       out_last
);

    localparam int DEPTH = gnms_pkg::FIFO_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int EW    = gnms_pkg::MAG_W + 1;

    logic [EW-1:0]    data_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] credit_reg;
    logic             pop;

    function automatic logic [PW-1:0] inc_ptr(input logic [PW-1:0] a);
        logic [PW-1:0] r;
        if (a == PW'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = a + PW'(1);
        end
        return r;
    endfunction

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign in_ready  = (credit_reg != CNT_W'(DEPTH));
    assign out_mag   = data_reg[rd_ptr_reg][gnms_pkg::MAG_W-1:0];
    assign out_last  = data_reg[rd_ptr_reg][EW-1];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= {push_last, push_mag};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            credit_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= inc_ptr(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= inc_ptr(rd_ptr_reg);
            end
            count_reg  <= count_reg + CNT_W'(push) - CNT_W'(pop);
            credit_reg <= credit_reg + CNT_W'(reserve) - CNT_W'(pop);
        end
    end

endmodule

// File: hdl/gradient_non_maximum_suppression_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_non_maximum_suppression_core
// 3x3 non-maximum suppression of gradient magnitudes on a raster stream.
// ----------------------------------------------------------------------------
// Takes one item per clock, pixel or flush, while tready is high. The result
// for a pixel is released when the pixel one row and one column further on is
// taken (or by a flush once the frame is complete) and passes through the item
// register and the judge window registers into the result queue. The window
// comes from a ring memory of 2*MAX_WIDTH+2 words with two read ports (one and
// two rows back), so each item costs two reads, and each pixel also one write,
// in the same cycle; a four-entry result queue decouples the output, and tready
// drops only while four results are outstanding. The ring needs no clearing
// after reset. Writing either register restarts the frame.
`include "assert_macros.svh"

module gradient_non_maximum_suppression_core #(
    parameter int MAX_WIDTH = gnms_pkg::MAX_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] grad_magnitude, [28:16] grad_angle
    input  logic        s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] thinned_magnitude
    output logic        m_tlast    // frame_last
);

    localparam int DIM_W = gnms_pkg::DIM_W;
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = (WW > DIM_W) ? WW : DIM_W;
    localparam int CW    = $clog2(MAX_WIDTH * gnms_pkg::MAX_HEIGHT + 1);
    localparam int DEPTH = 2 * MAX_WIDTH + 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int RESET_W = (MAX_WIDTH < gnms_pkg::DIM_RESET) ? MAX_WIDTH
                                                                : gnms_pkg::DIM_RESET;
    localparam int RESET_TOTAL = RESET_W * gnms_pkg::MAX_HEIGHT;

    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [CW-1:0]     total_reg;
    logic [CW-1:0]     total_next;
    logic              cfg_wr;
    logic [WW-1:0]     w_cur;
    logic [DIM_W-1:0]  h_cur;
    logic [WW-1:0]     w_src;
    logic [DIM_W-1:0]  h_src;

    logic                        accept;
    logic                        emit_now;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [gnms_pkg::WORD_W-1:0] wr_data;
    logic [AW-1:0]               rd_addr_mid;
    logic [AW-1:0]               rd_addr_top;
    logic [gnms_pkg::WORD_W-1:0] mid_word;
    logic [gnms_pkg::WORD_W-1:0] top_word;
    gnms_pkg::item_t             item;
    logic                        push;
    logic [gnms_pkg::MAG_W-1:0]  push_mag;
    logic                        push_last;

    function automatic logic [WW-1:0] clamp_width(input logic [DIM_W-1:0] v);
        logic [WW-1:0] r;
        if (v == '0)
        begin
            r = WW'(1);
        end
        else if (CMP_W'(v) > CMP_W'(MAX_WIDTH))
        begin
            r = WW'(MAX_WIDTH);
        end
        else
        begin
            r = WW'(v);
        end
        return r;
    endfunction

    function automatic logic [DIM_W-1:0] clamp_height(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > DIM_W'(gnms_pkg::MAX_HEIGHT))
        begin
            r = DIM_W'(gnms_pkg::MAX_HEIGHT);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign w_cur  = clamp_width(width_reg);
    assign h_cur  = clamp_height(height_reg);

    always_comb
    begin
        w_src = w_cur;
        h_src = h_cur;
        if (cfg_wr && (paddr[2] == gnms_pkg::REG_WIDTH))
        begin
            w_src = clamp_width(pwdata[DIM_W-1:0]);
        end
        if (cfg_wr && (paddr[2] == gnms_pkg::REG_HEIGHT))
        begin
            h_src = clamp_height(pwdata[DIM_W-1:0]);
        end
        total_next = CW'(w_src) * CW'(h_src);
    end

    always_comb
    begin
        case (paddr[2])
            gnms_pkg::REG_WIDTH:  prdata = 32'(width_reg);
            gnms_pkg::REG_HEIGHT: prdata = 32'(height_reg);
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(gnms_pkg::DIM_RESET);
            height_reg <= DIM_W'(gnms_pkg::DIM_RESET);
            total_reg  <= CW'(RESET_TOTAL);
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == gnms_pkg::REG_WIDTH)
            begin
                width_reg <= pwdata[DIM_W-1:0];
            end
            else
            begin
                height_reg <= pwdata[DIM_W-1:0];
            end
            total_reg <= total_next;
        end
    end

    assign accept = s_tvalid && s_tready;

    gnms_seq #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .restart     (cfg_wr),
        .accept      (accept),
        .is_flush    (s_tuser),
        .mag         (s_tdata[15:0]),
        .angle       (s_tdata[28:16]),
        .width       (w_cur),
        .height      (h_cur),
        .total       (total_reg),
        .emit_now    (emit_now),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_addr_mid (rd_addr_mid),
        .rd_addr_top (rd_addr_top),
        .item        (item)
    );

    gnms_ring_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ring (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_mid),
        .rd_addr_b (rd_addr_top),
        .rd_data_a (mid_word),
        .rd_data_b (top_word)
    );

    gnms_judge u_judge (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .mid_word  (mid_word),
        .top_word  (top_word),
        .push      (push),
        .push_mag  (push_mag),
        .push_last (push_last)
    );

    gnms_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .reserve   (accept && emit_now),
        .push      (push),
        .push_mag  (push_mag),
        .push_last (push_last),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_mag   (m_tdata),
        .out_last  (m_tlast)
    );

    `ASSERT_PROP(a_emit_reaches_queue, clk, rst_n, (accept && emit_now) |-> ##2 push, "result lost between accept and queue")
    `ASSERT_PROP(a_item_from_accept, clk, rst_n, item.valid |-> $past(accept), "window step without an accepted item")
    `ASSERT_NEVER(a_ring_addr_range, clk, rst_n, (32'(rd_addr_mid) >= DEPTH) || (32'(rd_addr_top) >= DEPTH) || (wr_en && (32'(wr_addr) >= DEPTH)), "ring address outside memory")

endmodule
